@@ src/phc_pkg.sv @@
// Package for the presence and height capture block: register map,
// mode and event codes, configuration and controller/datapath structs.
// No dependencies; imported by every other file of the block except phc_if.sv.
package phc_pkg;

  // Mode codes as shown on the result channel
  localparam logic [1:0] MODE_CAL  = 2'd0;
  localparam logic [1:0] MODE_WAIT = 2'd1;
  localparam logic [1:0] MODE_MEAS = 2'd2;
  localparam logic [1:0] MODE_LOCK = 2'd3;

  // Request codes on the input channel
  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_RESET  = 2'd2;
  localparam logic [1:0] REQ_CAL    = 2'd3;

  // Event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_CAL_OK   = 3'd1;
  localparam logic [2:0] EV_CAL_FAIL = 3'd2;
  localparam logic [2:0] EV_DETECT   = 3'd3;
  localparam logic [2:0] EV_LOCKED   = 3'd4;
  localparam logic [2:0] EV_LEFT     = 3'd5;

  // Register indexes (byte address is 4 * index)
  localparam logic [2:0] REG_PRESENCE  = 3'd0;
  localparam logic [2:0] REG_NOISE     = 3'd1;
  localparam logic [2:0] REG_LEAVE     = 3'd2;
  localparam logic [2:0] REG_WINDOW    = 3'd3;
  localparam logic [2:0] REG_OFFSET    = 3'd4;
  localparam logic [2:0] REG_THICKNESS = 3'd5;

  localparam int APB_ADDR_W = 5;

  // Measurement constants
  localparam logic [15:0] MIN_RESET = 16'd9999;
  localparam int CAL_SUM_W = 22;
  localparam int CAL_CNT_W = 7;
  localparam int HEIGHT_W  = 18;

  // Serial divider: one quotient bit per cycle over the whole sum
  localparam int DIV_STEPS = CAL_SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  typedef struct packed {
    logic [11:0]        presence_margin_mm;
    logic [11:0]        noise_floor_mm;
    logic [11:0]        leave_margin_mm;
    logic [15:0]        window_ms;
    logic signed [10:0] mount_offset_mm;
    logic [9:0]         plate_thickness_mm;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic step;        // apply the accepted item
    logic div_step;    // one divider iteration
    logic div_finish;  // write baseline from quotient, load result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_div;   // current item closes a calibration with valid samples
  } status_t;

endpackage

@@ src/phc_if.sv @@
// Handshake channel interfaces for the presence and height capture block:
// the request channel and the report channel, each with source/sink modports.
// Depends on nothing.
interface phc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] distance_mm;
  logic        timed_out;

  modport source (output valid, req_type, distance_mm, timed_out, input ready);
  modport sink   (input valid, req_type, distance_mm, timed_out, output ready);
endinterface

interface phc_rpt_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic               is_locked;
  logic signed [17:0] height_mm;
  logic [15:0]        baseline_mm;
  logic [2:0]         event_res;

  modport source (output valid, mode, is_locked, height_mm, baseline_mm, event_res,
                  input ready);
  modport sink   (input valid, mode, is_locked, height_mm, baseline_mm, event_res,
                  output ready);
endinterface

@@ src/presence_height_capture.sv @@
// Presence and height capture top level: one result item per request item.
// The result is registered and valid in the cycle after accept; the sample that closes a
// calibration with valid samples first runs the 22-step serial divider.
// Throughput: one item per cycle while the report side keeps up, except
// the calibration close. Reset (rst, synchronous): mode calibrating, baseline
// and height 0, registers at their defaults, no result pending.
module presence_height_capture
  import phc_pkg::*;
#(
  parameter int CAL_SAMPLES = 20
) (
  input  logic                  clk,
  input  logic                  rst,
  phc_req_if.sink               request,
  phc_rpt_if.source             report,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  phc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  phc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (report.valid),
    .out_ready (report.ready),
    .status    (status),
    .cmd       (cmd)
  );

  phc_dp #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .status      (status),
    .req_type    (request.req_type),
    .distance_mm (request.distance_mm),
    .timed_out   (request.timed_out),
    .mode        (report.mode),
    .is_locked   (report.is_locked),
    .height_mm   (report.height_mm),
    .baseline_mm (report.baseline_mm),
    .event_res   (report.event_res)
  );

endmodule

@@ src/phc_regs.sv @@
// APB-style configuration register file of the presence and height capture
// block. Depends on phc_pkg for the register map and cfg_t.
module phc_regs
  import phc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.presence_margin_mm <= 12'd200;
      cfg.noise_floor_mm     <= 12'd200;
      cfg.leave_margin_mm    <= 12'd100;
      cfg.window_ms          <= 16'd3000;
      cfg.mount_offset_mm    <= 11'sd0;
      cfg.plate_thickness_mm <= 10'd0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_PRESENCE:  cfg.presence_margin_mm <= pwdata[11:0];
        REG_NOISE:     cfg.noise_floor_mm     <= pwdata[11:0];
        REG_LEAVE:     cfg.leave_margin_mm    <= pwdata[11:0];
        REG_WINDOW:    cfg.window_ms          <= pwdata[15:0];
        REG_OFFSET:    cfg.mount_offset_mm    <= $signed(pwdata[10:0]);
        REG_THICKNESS: cfg.plate_thickness_mm <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      REG_PRESENCE:  prdata = {20'd0, cfg.presence_margin_mm};
      REG_NOISE:     prdata = {20'd0, cfg.noise_floor_mm};
      REG_LEAVE:     prdata = {20'd0, cfg.leave_margin_mm};
      REG_WINDOW:    prdata = {16'd0, cfg.window_ms};
      REG_OFFSET:    prdata = {21'd0, cfg.mount_offset_mm};
      REG_THICKNESS: prdata = {22'd0, cfg.plate_thickness_mm};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

@@ src/phc_ctrl.sv @@
// Controller of the presence and height capture block: handshakes, result
// valid flag and the sequencer of the serial calibration divider.
// Depends on phc_pkg for cmd_t, status_t and divider constants.
module phc_ctrl
  import phc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 accept;

  // Take a new item while idle and the result register is free or draining
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.step = accept;
        if (accept && status.needs_div) state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == DIV_LAST) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.div_finish = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance state and divider count
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      div_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_DIV) div_cnt <= div_cnt + DIV_CNT_W'(1);
      else                div_cnt <= '0;
    end
  end

  // Hold result valid until taken; a new load wins over a drain
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.step && !status.needs_div) || cmd.div_finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ src/phc_dp.sv @@
// Datapath of the presence and height capture block: mode and measurement
// state, calibration accumulator, serial divider and result register.
// Depends on phc_pkg for codes, cfg_t, cmd_t and status_t.
module phc_dp
  import phc_pkg::*;
#(
  parameter int CAL_SAMPLES = 20
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  cmd_t                       cmd,
  output status_t                    status,
  input  logic [1:0]                 req_type,
  input  logic [15:0]                distance_mm,
  input  logic                       timed_out,
  output logic [1:0]                 mode,
  output logic                       is_locked,
  output logic signed [HEIGHT_W-1:0] height_mm,
  output logic [15:0]                baseline_mm,
  output logic [2:0]                 event_res
);

  // Architectural state
  logic [1:0]                 mode_reg, mode_next;
  logic [15:0]                floor_distance, floor_next;
  logic [15:0]                min_seen, min_next;
  logic [15:0]                elapsed_ms, elapsed_next;
  logic signed [HEIGHT_W-1:0] held_height, held_next;
  logic [CAL_SUM_W-1:0]       cal_sum, cal_sum_next;
  logic [CAL_CNT_W-1:0]       cal_valid_count, cal_valid_next;
  logic [CAL_CNT_W-1:0]       cal_attempts, cal_attempts_next;
  logic [2:0]                 ev_next;
  logic                       div_start;

  // Divider registers
  logic [CAL_SUM_W-1:0] quo;
  logic [CAL_CNT_W-1:0] rem;
  logic [CAL_CNT_W-1:0] divisor;
  logic [CAL_CNT_W:0]   trial;
  logic                 q_bit;

  // Compare operands
  logic                       sample_ok;
  logic                       min_take;
  logic [15:0]                min_cand;
  logic signed [HEIGHT_W-1:0] base_s, range_s, enter_thr, leave_thr;
  logic signed [HEIGHT_W-1:0] offset_s, thick_s, min_s;

  assign sample_ok = !timed_out;
  assign base_s    = $signed({2'b00, floor_distance});
  assign range_s   = $signed({2'b00, distance_mm});
  assign enter_thr = base_s - $signed({6'd0, cfg.presence_margin_mm});
  assign leave_thr = base_s - $signed({6'd0, cfg.leave_margin_mm});
  assign offset_s  = {{(HEIGHT_W-11){cfg.mount_offset_mm[10]}}, cfg.mount_offset_mm};
  assign thick_s   = $signed({8'd0, cfg.plate_thickness_mm});

  // Minimum after this sample, counting only samples above the noise floor
  assign min_take  = (distance_mm > {4'd0, cfg.noise_floor_mm}) && (distance_mm < min_seen);
  assign min_cand  = min_take ? distance_mm : min_seen;
  assign min_s     = $signed({2'b00, min_cand});

  // Next state for one item
  always_comb begin
    mode_next         = mode_reg;
    floor_next        = floor_distance;
    min_next          = min_seen;
    elapsed_next      = elapsed_ms;
    held_next         = held_height;
    cal_sum_next      = cal_sum;
    cal_valid_next    = cal_valid_count;
    cal_attempts_next = cal_attempts;
    ev_next           = EV_NONE;
    div_start         = 1'b0;
    case (req_type)
      REQ_RESET: begin
        mode_next = MODE_WAIT;
        held_next = '0;
        min_next  = MIN_RESET;
      end
      REQ_CAL: begin
        mode_next         = MODE_CAL;
        cal_sum_next      = '0;
        cal_valid_next    = '0;
        cal_attempts_next = '0;
      end
      REQ_TICK: begin
        if (mode_reg == MODE_MEAS && elapsed_ms != 16'hFFFF)
          elapsed_next = elapsed_ms + 16'd1;
      end
      REQ_SAMPLE: begin
        if (mode_reg == MODE_CAL) begin
          // Accumulate; close the run after the last attempt
          if (sample_ok) begin
            cal_sum_next   = cal_sum + {6'd0, distance_mm};
            cal_valid_next = cal_valid_count + CAL_CNT_W'(1);
          end
          cal_attempts_next = cal_attempts + CAL_CNT_W'(1);
          if (cal_attempts_next >= CAL_CNT_W'(CAL_SAMPLES)) begin
            mode_next = MODE_WAIT;
            if (cal_valid_next != '0) begin
              div_start = 1'b1;
              ev_next   = EV_CAL_OK;
            end else begin
              floor_next = '0;
              ev_next    = EV_CAL_FAIL;
            end
          end
        end else if (sample_ok) begin
          if (mode_reg == MODE_WAIT) begin
            if (floor_distance != '0 && range_s < enter_thr) begin
              mode_next    = MODE_MEAS;
              elapsed_next = '0;
              min_next     = MIN_RESET;
              held_next    = '0;
              ev_next      = EV_DETECT;
            end
          end else if (mode_reg == MODE_MEAS) begin
            // Track minimum, then check the window
            min_next = min_cand;
            if (elapsed_ms >= cfg.window_ms) begin
              held_next = base_s - min_s + offset_s - thick_s;
              mode_next = MODE_LOCK;
              ev_next   = EV_LOCKED;
            end
          end else begin
            if (range_s > leave_thr) begin
              mode_next = MODE_WAIT;
              ev_next   = EV_LEFT;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign status.needs_div = div_start;

  // Update architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= MODE_CAL;
      floor_distance  <= '0;
      min_seen        <= MIN_RESET;
      elapsed_ms      <= '0;
      held_height     <= '0;
      cal_sum         <= '0;
      cal_valid_count <= '0;
      cal_attempts    <= '0;
    end else if (cmd.step) begin
      mode_reg        <= mode_next;
      floor_distance  <= floor_next;
      min_seen        <= min_next;
      elapsed_ms      <= elapsed_next;
      held_height     <= held_next;
      cal_sum         <= cal_sum_next;
      cal_valid_count <= cal_valid_next;
      cal_attempts    <= cal_attempts_next;
    end else if (cmd.div_finish) begin
      floor_distance <= quo[15:0];
    end
  end

  // Restoring divider, one quotient bit per cycle
  assign trial = {rem, quo[CAL_SUM_W-1]};
  assign q_bit = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (cmd.step && div_start) begin
      quo     <= cal_sum_next;
      rem     <= '0;
      divisor <= cal_valid_next;
    end else if (cmd.div_step) begin
      quo <= {quo[CAL_SUM_W-2:0], q_bit};
      rem <= q_bit ? CAL_CNT_W'(trial - {1'b0, divisor}) : trial[CAL_CNT_W-1:0];
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.step && !div_start) begin
      mode        <= mode_next;
      height_mm   <= held_next;
      baseline_mm <= floor_next;
      event_res   <= ev_next;
    end else if (cmd.div_finish) begin
      mode        <= mode_reg;
      height_mm   <= held_height;
      baseline_mm <= quo[15:0];
      event_res   <= EV_CAL_OK;
    end
  end

  assign is_locked = (mode == MODE_LOCK);

endmodule

@@ src/phc_checker.sv @@
// Port-level assertions for the presence and height capture block, bound
// to the top level. Depends on phc_pkg for mode and event codes.
module phc_checker
  import phc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rpt_valid,
  input logic        rpt_ready,
  input logic [1:0]  rpt_mode,
  input logic        rpt_is_locked,
  input logic [17:0] rpt_height_mm,
  input logic [15:0] rpt_baseline_mm,
  input logic [2:0]  rpt_event_res
);

  // A stalled result holds its payload
  a_rpt_hold: assert property (@(posedge clk) disable iff (rst)
    rpt_valid && !rpt_ready |=>
      $stable({rpt_mode, rpt_is_locked, rpt_height_mm, rpt_baseline_mm, rpt_event_res}))
    else $error("report payload changed while stalled");

  // No new item taken while a result is stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    req_ready && rpt_valid |-> rpt_ready)
    else $error("request accepted over a pending report");

  // Lock flag follows the mode
  a_lock_flag: assert property (@(posedge clk) disable iff (rst)
    rpt_valid |-> (rpt_is_locked == (rpt_mode == MODE_LOCK)))
    else $error("is_locked disagrees with mode");

  // Events agree with the mode they lead to
  a_event_mode: assert property (@(posedge clk) disable iff (rst)
    rpt_valid |->
      ((rpt_event_res != EV_LOCKED) || (rpt_mode == MODE_LOCK)) &&
      ((rpt_event_res != EV_DETECT) || (rpt_mode == MODE_MEAS && rpt_height_mm == '0)) &&
      ((rpt_event_res != EV_CAL_FAIL) || (rpt_mode == MODE_WAIT && rpt_baseline_mm == '0)) &&
      ((rpt_event_res != EV_CAL_OK) || (rpt_mode == MODE_WAIT)) &&
      ((rpt_event_res != EV_LEFT) || (rpt_mode == MODE_WAIT)))
    else $error("event code inconsistent with reported mode");

endmodule

bind presence_height_capture phc_checker u_phc_checker (
  .clk             (clk),
  .rst             (rst),
  .req_ready       (request.ready),
  .rpt_valid       (report.valid),
  .rpt_ready       (report.ready),
  .rpt_mode        (report.mode),
  .rpt_is_locked   (report.is_locked),
  .rpt_height_mm   (report.height_mm),
  .rpt_baseline_mm (report.baseline_mm),
  .rpt_event_res   (report.event_res)
);
